// File: rtl/asob_pkg.sv
// Shared types, constants and the divider step for the source-over blender.
package asob_pkg;

	localparam int CHAN_W         = 8;
	localparam int NCHAN          = 3;
	localparam int PIX_W          = 32;
	localparam int W_W            = 16;
	localparam int NUM_W          = 24;
	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = CHAN_W / BITS_PER_STAGE;

	// floor(w/255) == (w * 0x8081) >> 23 for every 16-bit w
	localparam logic [W_W-1:0] ALPHA_RECIP = 16'h8081;
	localparam int             ALPHA_SHIFT = 23;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// one colour channel in the restoring divider
	typedef struct packed {
		logic [W_W-1:0]    rem;
		logic [CHAN_W-1:0] low;
		logic [CHAN_W-1:0] quo;
	} div_lane_t;

	// everything that travels down the divider chain
	typedef struct packed {
		logic                         valid;
		logic                         zero;
		logic [W_W-1:0]               w;
		logic [CHAN_W-1:0]            alpha;
		div_lane_t [NCHAN-1:0]        lane;
	} div_word_t;

	// one restoring step: shift in a dividend bit, subtract if it fits
	function automatic div_lane_t div_step(input div_lane_t l, input logic [W_W-1:0] w);
		logic [W_W:0] trial;
		div_lane_t    r;
		trial = {l.rem, l.low[CHAN_W-1]};
		r.low = {l.low[CHAN_W-2:0], 1'b0};
		if (trial >= {1'b0, w}) begin
			r.rem = W_W'(trial - {1'b0, w});
			r.quo = {l.quo[CHAN_W-2:0], 1'b1};
		end else begin
			r.rem = trial[W_W-1:0];
			r.quo = {l.quo[CHAN_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// File: rtl/asob_in_if.sv
// Input channel: destination and source pixel pair with valid/ready.
interface asob_in_if;
	logic                        valid;
	logic                        ready;
	logic [asob_pkg::PIX_W-1:0]  dest_pixel;
	logic [asob_pkg::PIX_W-1:0]  source_pixel;

	modport source (output valid, output dest_pixel, output source_pixel, input ready);
	modport sink (input valid, input dest_pixel, input source_pixel, output ready);
endinterface

// File: rtl/asob_out_if.sv
// Output channel: blended pixel with valid/ready.
interface asob_out_if;
	logic                        valid;
	logic                        ready;
	logic [asob_pkg::PIX_W-1:0]  blended_pixel;

	modport source (output valid, output blended_pixel, input ready);
	modport sink (input valid, input blended_pixel, output ready);
endinterface

// File: rtl/asob_front.sv
// Front pipeline: weights, numerators, total weight, alpha and divider setup.
module asob_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [asob_pkg::PIX_W-1:0]  dest_pixel,
	input  logic [asob_pkg::PIX_W-1:0]  source_pixel,
	output asob_pkg::div_word_t         word_s3
);
	import asob_pkg::*;

	logic                     valid_s1, valid_s2;
	logic [W_W-1:0]           sw_s1, dw_s1;
	logic [CHAN_W-1:0]        src_col_s1 [NCHAN];
	logic [CHAN_W-1:0]        dst_col_s1 [NCHAN];
	logic [W_W-1:0]           w_s2;
	logic [NUM_W-1:0]         num_s2 [NCHAN];

	logic [CHAN_W-1:0]        sa, da;
	logic [W_W-1:0]           sw_c, dw_c;
	logic [W_W:0]             w_sum;
	logic [NUM_W:0]           num_c [NCHAN];
	logic [2*W_W-1:0]         alpha_prod;

	// stage 1: per-pixel weights
	assign sa   = source_pixel[PIX_W-1 -: CHAN_W];
	assign da   = dest_pixel[PIX_W-1 -: CHAN_W];
	assign sw_c = {sa, {CHAN_W{1'b0}}} - W_W'(sa);
	assign dw_c = W_W'(da) * W_W'(CHAN_MAX - sa);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sw_s1 <= sw_c;
			dw_s1 <= dw_c;
			for (int c = 0; c < NCHAN; c++) begin
				src_col_s1[c] <= source_pixel[c*CHAN_W +: CHAN_W];
				dst_col_s1[c] <= dest_pixel[c*CHAN_W +: CHAN_W];
			end
		end
	end

	// stage 2: total weight and weighted colour sums
	assign w_sum = {1'b0, sw_s1} + {1'b0, dw_s1};
	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			num_c[c] = (NUM_W+1)'(NUM_W'(src_col_s1[c]) * NUM_W'(sw_s1))
			         + (NUM_W+1)'(NUM_W'(dst_col_s1[c]) * NUM_W'(dw_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2 <= w_sum[W_W-1:0];
			for (int c = 0; c < NCHAN; c++) begin
				num_s2[c] <= num_c[c][NUM_W-1:0];
			end
		end
	end

	// stage 3: alpha by reciprocal, load divider (quotient fits 8 bits, so rem < w)
	assign alpha_prod = (2*W_W)'(w_s2) * (2*W_W)'(ALPHA_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s3 <= '0;
		end else if (en) begin
			word_s3.valid <= valid_s2;
			word_s3.zero  <= (w_s2 == '0);
			word_s3.w     <= w_s2;
			word_s3.alpha <= alpha_prod[ALPHA_SHIFT +: CHAN_W];
			for (int c = 0; c < NCHAN; c++) begin
				word_s3.lane[c].rem <= num_s2[c][NUM_W-1 -: W_W];
				word_s3.lane[c].low <= num_s2[c][CHAN_W-1:0];
				word_s3.lane[c].quo <= '0;
			end
		end
	end

endmodule

// File: rtl/asob_div_stage.sv
// One divider stage: a few restoring steps for every colour channel.
module asob_div_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  asob_pkg::div_word_t  word_in,
	output asob_pkg::div_word_t  word_sn
);
	import asob_pkg::*;

	div_word_t nxt;

	// advance each lane by the stage's share of quotient bits
	always_comb begin
		nxt = word_in;
		for (int c = 0; c < NCHAN; c++) begin
			for (int b = 0; b < BITS_PER_STAGE; b++) begin
				nxt.lane[c] = div_step(nxt.lane[c], word_in.w);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_sn <= '0;
		end else if (en) begin
			word_sn <= nxt;
		end
	end

endmodule

// File: rtl/argb_source_over_blend.sv
// Top level of the source-over ARGB8888 compositor.
//
// Channels: in_ch carries a destination and a source pixel (ARGB, 8 bits
// per channel, straight alpha); out_ch returns their source-over composite.
// Both use valid/ready; a transfer happens when valid and ready are high.
//
// From input transfer to output valid a pixel passes three front stages
// (weights, weighted sums, alpha and divider load) and four divider
// stages that each resolve two quotient bits of all three colour channels.
// Fully pipelined: one pixel per clock unless the receiver stalls.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops; while the output is empty the pipeline advances
// and bubbles move along with it. Nothing is lost or repeated.
//
// Reset clears all valid bits; in_ch.ready is high as soon as reset is
// released. Both alphas zero gives a zero pixel.
module argb_source_over_blend (
	input  logic        clk,
	input  logic        arst_n,
	asob_in_if.sink     in_ch,
	asob_out_if.source  out_ch
);
	import asob_pkg::*;

	logic      en;
	div_word_t word [DIV_STAGES+1];
	div_word_t last;

	// advance all stages unless a result is waiting on a stalled receiver
	assign en          = !last.valid || out_ch.ready;
	assign in_ch.ready = en;

	asob_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_ch.valid),
		.dest_pixel   (in_ch.dest_pixel),
		.source_pixel (in_ch.source_pixel),
		.word_s3      (word[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		asob_div_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.word_in (word[g]),
			.word_sn (word[g+1])
		);
	end

	assign last = word[DIV_STAGES];

	// pack the result; zero total weight gives a zero pixel
	assign out_ch.valid = last.valid;
	always_comb begin
		if (last.zero) begin
			out_ch.blended_pixel = '0;
		end else begin
			out_ch.blended_pixel = {last.alpha, last.lane[2].quo,
			                        last.lane[1].quo, last.lane[0].quo};
		end
	end

	// input is refused only while a finished result waits
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (out_ch.valid && !out_ch.ready))
		else $error("input refused without an output stall");

	// divider load must start with partial remainders below the weight
	a_div_load: assert property (@(posedge clk) disable iff (!arst_n)
		(word[0].valid && !word[0].zero) |->
		((word[0].lane[0].rem < word[0].w) && (word[0].lane[1].rem < word[0].w) &&
		 (word[0].lane[2].rem < word[0].w)))
		else $error("divider loaded with remainder not below weight");

	// finished division leaves every remainder below the weight
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(last.valid && !last.zero) |->
		((last.lane[0].rem < last.w) && (last.lane[1].rem < last.w) &&
		 (last.lane[2].rem < last.w)))
		else $error("final remainder not below weight");

endmodule

// File: tb/sv/asob_blend_checker.sv
// Checker for the source-over blender: predicts each composite and compares results in order.
module asob_blend_checker (
	input  logic  clk,
	input  logic  arst_n,
	asob_in_if    in_mon,
	asob_out_if   out_mon,
	input  logic  drain_check,
	output int    results_pending,
	output int    fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import asob_pkg::*;

	typedef struct packed {
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} argb_t;

	logic [PIX_W-1:0] expected_blends [$];
	int               results_seen;
	logic             leftovers_checked;

	// Weighted average of one colour channel, floor division by the total weight.
	function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] src_c,
			input logic [CHAN_W-1:0] dst_c, input int unsigned src_w,
			input int unsigned dst_w, input int unsigned total_w);
		int unsigned num;
		num = int'(src_c) * src_w + int'(dst_c) * dst_w;
		return CHAN_W'(num / total_w);
	endfunction

	// Source-over composite of straight-alpha pixels in exact integer form.
	function automatic logic [PIX_W-1:0] source_over(input argb_t dst, input argb_t src);
		int unsigned src_w;
		int unsigned dst_w;
		int unsigned total_w;
		argb_t       comp;
		src_w   = int'(src.a) * int'(CHAN_MAX);
		dst_w   = int'(dst.a) * (int'(CHAN_MAX) - int'(src.a));
		total_w = src_w + dst_w;
		if (total_w == 0)
			return '0;
		comp.a = CHAN_W'(total_w / int'(CHAN_MAX));
		comp.r = mix_channel(src.r, dst.r, src_w, dst_w, total_w);
		comp.g = mix_channel(src.g, dst.g, src_w, dst_w, total_w);
		comp.b = mix_channel(src.b, dst.b, src_w, dst_w, total_w);
		return comp;
	endfunction

	task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] got,
			input logic [PIX_W-1:0] want);
		$display("[%0t] mismatch: %s (result %0d): got %08h, predicted %08h",
			$realtime, what, results_seen, got, want);
		fail_count++;
	endtask

	// Record each input transfer, check each output transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_blends.delete();
			results_pending   = 0;
			results_seen      = 0;
			leftovers_checked = 1'b0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_blends.size() == 0) begin
					flag_mismatch("pixel with nothing outstanding", out_mon.blended_pixel, '0);
				end else begin
					logic [PIX_W-1:0] want;
					want = expected_blends.pop_front();
					if (out_mon.blended_pixel !== want)
						flag_mismatch("blended_pixel", out_mon.blended_pixel, want);
				end
				results_seen++;
			end
			if (in_mon.valid && in_mon.ready)
				expected_blends = {expected_blends,
					source_over(in_mon.dest_pixel, in_mon.source_pixel)};
			results_pending = expected_blends.size();
			// at end of run, anything still queued never came out
			if (drain_check && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				while (expected_blends.size() != 0)
					flag_mismatch("pixel never delivered", '0, expected_blends.pop_front());
				results_pending = 0;
			end
		end
	end

endmodule

// File: tb/sv/testbench.sv
// Top of the blender testbench: clock, reset, pixel stimulus, output stalls and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import asob_pkg::*;

	localparam int DIRECTED_N = 22;
	localparam int RANDOM_N   = 600;
	localparam int HOLD_LEN   = 80;

	// {dest_pixel, source_pixel}
	localparam logic [2*PIX_W-1:0] DIRECTED_PAIRS [DIRECTED_N] = '{
		{32'h00000000, 32'h00000000},  // both alphas zero, all clear
		{32'h00FFFFFF, 32'h00FFFFFF},  // both alphas zero, colours full
		{32'h00123456, 32'h00ABCDEF},
		{32'hFF102030, 32'hFFA0B0C0},  // opaque over opaque
		{32'h00FFFFFF, 32'hFF000000},  // opaque over clear
		{32'h80808080, 32'hFFFFFFFF},
		{32'hFF123456, 32'h00FFFFFF},  // clear source over visible dest
		{32'h01ABCDEF, 32'h00000000},
		{32'hFFFFFFFF, 32'hFFFFFFFF},
		{32'h00000000, 32'h01FFFFFF},
		{32'h01FFFFFF, 32'h00000000},
		{32'hFFFFFFFF, 32'h01000000},
		{32'hFF000000, 32'hFEFFFFFF},
		{32'h01000000, 32'hFEFFFFFF},
		{32'h80FF00FF, 32'h8000FF00},
		{32'h7F55AA55, 32'h81AA55AA},
		{32'hFFFFFFFF, 32'h80000000},
		{32'h01010101, 32'h01FEFEFE},
		{32'hFE0000FF, 32'h02FF0000},
		{32'h00AAAAAA, 32'h7F555555},
		{32'hC0123456, 32'h40FEDCBA},
		{32'hFF00FF00, 32'hFEFF00FF}
	};

	// long output hold-offs start once this many pairs went in
	localparam int HOLD_MARKS [3] = '{60, 260, 480};

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_STROBE} recv_mode_t;

	logic clk;
	logic arst_n;
	logic drain_check;
	logic long_hold;
	int   pairs_sent;
	int   results_pending;
	int   fail_count;

	asob_in_if  pix_in ();
	asob_out_if pix_out ();

	argb_source_over_blend dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (pix_in),
		.out_ch (pix_out)
	);

	asob_blend_checker blend_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_mon          (pix_in),
		.out_mon         (pix_out),
		.drain_check     (drain_check),
		.results_pending (results_pending),
		.fail_count      (fail_count)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Bias alpha toward the edges where the special cases live.
	function automatic logic [CHAN_W-1:0] pick_alpha();
		case ($urandom_range(9, 0))
			0: return '0;
			1: return CHAN_MAX;
			2: return 8'd1;
			3: return CHAN_MAX - 8'd1;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	function automatic logic [CHAN_W-1:0] pick_colour();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return CHAN_MAX;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		return {pick_alpha(), pick_colour(), pick_colour(), pick_colour()};
	endfunction

	// Offer one pair and hold it until the transfer.
	task automatic offer_pair(input logic [PIX_W-1:0] dst, input logic [PIX_W-1:0] src);
		@(negedge clk);
		pix_in.valid        <= 1'b1;
		pix_in.dest_pixel   <= dst;
		pix_in.source_pixel <= src;
		do
			@(posedge clk);
		while (!(pix_in.valid && pix_in.ready));
		pairs_sent++;
	endtask

	// Drop valid for a few cycles with junk on the data lines.
	task automatic idle_input(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			pix_in.valid        <= 1'b0;
			pix_in.dest_pixel   <= $urandom;
			pix_in.source_pixel <= $urandom;
		end
	endtask

	// Stop sending until every outstanding pixel has come back.
	task automatic await_empty();
		idle_input(1);
		while (results_pending != 0)
			@(negedge clk);
	endtask

	// Output stalls: a changing pattern, with long hold-offs at fixed points in the run.
	initial begin : recv_stalls
		recv_mode_t mode;
		int         span;
		int         phase;
		int         hold_left;
		int         mark_idx;
		pix_out.ready = 1'b0;
		long_hold     = 1'b0;
		mode          = RDY_ALWAYS;
		span          = 0;
		phase         = 0;
		hold_left     = 0;
		mark_idx      = 0;
		forever begin
			@(negedge clk);
			if (mark_idx < 3 && pairs_sent >= HOLD_MARKS[mark_idx]) begin
				hold_left = HOLD_LEN;
				mark_idx++;
			end
			if (hold_left > 0) begin
				hold_left--;
				long_hold     <= 1'b1;
				pix_out.ready <= 1'b0;
			end else begin
				long_hold <= 1'b0;
				if (span == 0) begin
					mode = recv_mode_t'($urandom_range(3, 0));
					span = $urandom_range(150, 20);
				end
				span--;
				phase++;
				case (mode)
					RDY_ALWAYS: pix_out.ready <= 1'b1;
					RDY_COIN:   pix_out.ready <= 1'($urandom_range(1, 0));
					RDY_MOSTLY: pix_out.ready <= ($urandom_range(9, 0) != 0);
					RDY_STROBE: pix_out.ready <= (phase % 3 == 0);
					default:    pix_out.ready <= 1'b1;
				endcase
			end
		end
	end

	// Reset, directed pairs, random bursts, drain and verdict.
	initial begin : stimulus
		int  burst;
		int  waited;
		bit  pause_done;
		arst_n              = 1'b0;
		drain_check         = 1'b0;
		pairs_sent          = 0;
		pause_done          = 1'b0;
		pix_in.valid        = 1'b0;
		pix_in.dest_pixel   = '0;
		pix_in.source_pixel = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_PAIRS[i])
			offer_pair(DIRECTED_PAIRS[i][2*PIX_W-1:PIX_W], DIRECTED_PAIRS[i][PIX_W-1:0]);
		await_empty();

		while (pairs_sent < DIRECTED_N + RANDOM_N) begin
			burst = $urandom_range(24, 1);
			repeat (burst)
				offer_pair(pick_pixel(), pick_pixel());
			if (!pause_done && pairs_sent >= 330) begin
				pause_done = 1'b1;
				await_empty();
			end else if (!long_hold && $urandom_range(3, 0) != 0) begin
				idle_input($urandom_range(6, 1));
			end
		end
		idle_input(1);

		// drain, then allow for the pipeline depth
		waited = 0;
		while (results_pending != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (20) @(negedge clk);
		drain_check <= 1'b1;
		repeat (2) @(negedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: argb_source_over_blend.f
rtl/asob_pkg.sv
rtl/asob_in_if.sv
rtl/asob_out_if.sv
rtl/asob_front.sv
rtl/asob_div_stage.sv
rtl/argb_source_over_blend.sv
tb/sv/asob_blend_checker.sv
tb/sv/testbench.sv
